### sv/ofbtr_pkg.sv
// ----------------------------------------------------------------------------
// ofbtr_pkg: shared types and constants for the page framebuffer text renderer
// Item and result structs, operation codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package ofbtr_pkg;

  // Default geometry and glyph table size
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int GLYPH_DEPTH_DEF   = 4096;

  // Largest value the glyph address reduction sees: glyph index 127 times height 63
  localparam int RED_MAX = 127 * 63;
  localparam int RED_W   = 13;

  // Operation codes
  localparam logic [2:0] FUNC_FILL   = 3'd0;
  localparam logic [2:0] FUNC_PIXEL  = 3'd1;
  localparam logic [2:0] FUNC_CURSOR = 3'd2;
  localparam logic [2:0] FUNC_CHAR   = 3'd3;
  localparam logic [2:0] FUNC_LOAD   = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_FONT_WIDTH  = 1'b0;
  localparam logic CFG_FONT_HEIGHT = 1'b1;

  localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [5:0] FONT_HEIGHT_RST = 6'd10;

  // First printable code; glyph index is the code minus this
  localparam logic [6:0] CHAR_BASE = 7'd32;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        color;
    logic [6:0]  char_code;
    logic [11:0] font_addr;
    logic [15:0] font_word;
    logic [2:0]  page;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
  } out_t;

endpackage

### sv/ofbtr_ram.sv
// ----------------------------------------------------------------------------
// ofbtr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module ofbtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/oled_page_framebuffer_text_renderer_top.sv
// ----------------------------------------------------------------------------
// oled_page_framebuffer_text_renderer_top: page-organized text renderer
// Frame store, glyph table and text cursor driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on in_valid/in_data and transfer when in_stall is low. One
//   result per item leaves on out_valid/out_data and transfers when out_stall
//   is low. cfg_we/cfg_index/cfg_wdata set font width and height; write them
//   only while the block is idle.
//   The block works on one item at a time; in_stall is high while it is busy.
//   Set cursor, pixel, read byte and unused codes pass straight from idle to
//   the done state; load glyph word and draw character first fold the glyph
//   address into the table through the shared address-reduction unit
//   (one compare/subtract step at the default glyph table size). Draw
//   character then reads one glyph word per row and draws it column by column,
//   or only advances the cursor when width or height is zero. Fill sweeps the
//   whole frame, one frame byte written per cycle through the single
//   write port. Each drawn pixel is a read-modify-write of one frame byte.
//   After reset the frame store is cleared by a sweep of one byte per cycle
//   and no item is taken until it ends.
//   The result sits in an output register; while the receiver stalls, the
//   next item can still be taken and run, and waits at its end for the slot.
// ----------------------------------------------------------------------------
module oled_page_framebuffer_text_renderer_top #(
  parameter int SCREEN_WIDTH  = ofbtr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ofbtr_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_DEPTH   = ofbtr_pkg::GLYPH_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ofbtr_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ofbtr_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [5:0]      cfg_wdata
);

  import ofbtr_pkg::*;

  localparam int FB_PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_BYTES  = SCREEN_WIDTH * FB_PAGES;
  localparam int FA_W      = $clog2(FB_BYTES);
  localparam int GA_W      = $clog2(GLYPH_DEPTH);
  localparam int MOD_RAW   = $clog2(RED_MAX / GLYPH_DEPTH + 1);
  localparam int MOD_STEPS = (MOD_RAW > 1) ? MOD_RAW : 1;
  localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_GWR   = 8'b0000_1000,
    S_GREAD = 8'b0001_0000,
    S_GLOAD = 8'b0010_0000,
    S_PIX   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        func_r, func_nxt;
  logic              color_r, color_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [4:0]        font_width_r;
  logic [5:0]        font_height_r;
  logic [7:0]        cursor_col_r, cursor_col_nxt;
  logic [7:0]        cursor_row_r, cursor_row_nxt;
  logic [FA_W-1:0]   fa_r, fa_nxt;
  logic              fill_val_r, fill_val_nxt;
  logic              sweep_item_r, sweep_item_nxt;
  logic [RED_W-1:0]  red_r, red_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [GA_W-1:0]   ga_r, ga_nxt;
  logic [15:0]       word_r, word_nxt;
  logic [15:0]       shift_r, shift_nxt;
  logic [5:0]        i_r, i_nxt;
  logic [4:0]        j_r, j_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [7:0]        y_r, y_nxt;
  logic              pend_r, pend_nxt;
  logic [FA_W-1:0]   pa_r, pa_nxt;
  logic [2:0]        pbit_r, pbit_nxt;
  logic              pval_r, pval_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  // Shared reduction unit: conditional subtract of the table size, shifted
  logic [31:0]       mod_thr;
  logic              red_ge;
  logic [RED_W-1:0]  red_step;
  logic [GA_W-1:0]   ga_inc;
  logic [6:0]        gidx;
  logic [7:0]        rd_val;

  // RAM ports
  logic              fb_we, fb_re;
  logic [FA_W-1:0]   fb_waddr, fb_raddr;
  logic [7:0]        fb_wdata, fb_q, pmask;
  logic              gl_we, gl_re;
  logic [GA_W-1:0]   gl_raddr;
  logic [15:0]       gl_q;

  assign mod_thr  = 32'(GLYPH_DEPTH) << k_r;
  assign red_ge   = 32'(red_r) >= mod_thr;
  assign red_step = red_ge ? RED_W'(32'(red_r) - mod_thr) : red_r;
  assign ga_inc   = (ga_r == GA_W'(GLYPH_DEPTH - 1)) ? '0 : ga_r + 1'b1;
  assign gidx     = in_data.char_code - CHAR_BASE;
  assign pmask    = 8'd1 << pbit_r;
  assign rd_val   = (func_r == FUNC_READ && rd_ok_r) ? fb_q : 8'h00;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Frame write: sweep fills, otherwise the pending read-modify-write lands
  always_comb begin
    fb_we    = 1'b0;
    fb_waddr = pa_r;
    fb_wdata = pval_r ? (fb_q | pmask) : (fb_q & ~pmask);
    if (state_r == S_SWEEP) begin
      fb_we    = 1'b1;
      fb_waddr = fa_r;
      fb_wdata = {8{fill_val_r}};
    end else if (pend_r) begin
      fb_we = 1'b1;
    end
  end

  assign gl_we = (state_r == S_GWR);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    color_nxt      = color_r;
    rd_ok_nxt      = rd_ok_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    fa_nxt         = fa_r;
    fill_val_nxt   = fill_val_r;
    sweep_item_nxt = sweep_item_r;
    red_nxt        = red_r;
    k_nxt          = k_r;
    ga_nxt         = ga_r;
    word_nxt       = word_r;
    shift_nxt      = shift_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    pend_nxt       = 1'b0;
    pa_nxt         = pa_r;
    pbit_nxt       = pbit_r;
    pval_nxt       = pval_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    fb_re          = 1'b0;
    fb_raddr       = FA_W'(32'(in_data.pos_y[7:3]) * SCREEN_WIDTH + 32'(in_data.pos_x));
    gl_re          = 1'b0;
    gl_raddr       = ga_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SWEEP: begin
        fa_nxt = fa_r + 1'b1;
        if (fa_r == FA_W'(FB_BYTES - 1)) begin
          fa_nxt    = '0;
          state_nxt = sweep_item_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          color_nxt = in_data.color;
          rd_ok_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_data.func)
            FUNC_FILL: begin
              fill_val_nxt   = in_data.color;
              sweep_item_nxt = 1'b1;
              fa_nxt         = '0;
              state_nxt      = S_SWEEP;
            end
            FUNC_PIXEL: begin
              if (32'(in_data.pos_x) < SCREEN_WIDTH &&
                  32'(in_data.pos_y) < SCREEN_HEIGHT) begin
                fb_re    = 1'b1;
                pend_nxt = 1'b1;
                pa_nxt   = fb_raddr;
                pbit_nxt = in_data.pos_y[2:0];
                pval_nxt = in_data.color;
              end
            end
            FUNC_CURSOR: begin
              cursor_col_nxt = in_data.pos_x;
              cursor_row_nxt = in_data.pos_y;
            end
            FUNC_CHAR: begin
              if (font_width_r == 5'd0 || font_height_r == 6'd0) begin
                cursor_col_nxt = cursor_col_r + {3'b000, font_width_r};
              end else begin
                red_nxt   = RED_W'({6'b0, gidx} * {7'b0, font_height_r});
                k_nxt     = KW'(MOD_STEPS - 1);
                i_nxt     = '0;
                state_nxt = S_MOD;
              end
            end
            FUNC_LOAD: begin
              red_nxt   = RED_W'(in_data.font_addr);
              word_nxt  = in_data.font_word;
              k_nxt     = KW'(MOD_STEPS - 1);
              state_nxt = S_MOD;
            end
            FUNC_READ: begin
              fb_raddr = FA_W'(32'(in_data.page) * SCREEN_WIDTH + 32'(in_data.pos_x));
              if (32'(in_data.pos_x) < SCREEN_WIDTH && 32'(in_data.page) < FB_PAGES) begin
                fb_re     = 1'b1;
                rd_ok_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MOD: begin
        red_nxt = red_step;
        k_nxt   = k_r - 1'b1;
        if (k_r == '0) begin
          ga_nxt    = red_step[GA_W-1:0];
          state_nxt = (func_r == FUNC_LOAD) ? S_GWR : S_GREAD;
        end
      end

      S_GWR: begin
        state_nxt = S_DONE;
      end

      S_GREAD: begin
        gl_re     = 1'b1;
        state_nxt = S_GLOAD;
      end

      S_GLOAD: begin
        shift_nxt = gl_q;
        j_nxt     = '0;
        x_nxt     = cursor_col_r;
        y_nxt     = cursor_row_r + {2'b00, i_r};
        state_nxt = S_PIX;
      end

      S_PIX: begin
        fb_raddr = FA_W'(32'(y_r[7:3]) * SCREEN_WIDTH + 32'(x_r));
        if (32'(x_r) < SCREEN_WIDTH && 32'(y_r) < SCREEN_HEIGHT) begin
          fb_re    = 1'b1;
          pend_nxt = 1'b1;
          pa_nxt   = fb_raddr;
          pbit_nxt = y_r[2:0];
          pval_nxt = shift_r[15] ? color_r : ~color_r;
        end
        // advance one column; bits past the glyph word shift in clear
        shift_nxt = {shift_r[14:0], 1'b0};
        x_nxt     = x_r + 8'd1;
        j_nxt     = j_r + 5'd1;
        if (j_r == font_width_r - 5'd1) begin
          if (i_r == font_height_r - 6'd1) begin
            cursor_col_nxt = cursor_col_r + {3'b000, font_width_r};
            state_nxt      = S_DONE;
          end else begin
            i_nxt     = i_r + 6'd1;
            ga_nxt    = ga_inc;
            gl_re     = 1'b1;
            gl_raddr  = ga_inc;
            state_nxt = S_GLOAD;
          end
        end
      end

      S_DONE: begin
        // hold until the output slot frees up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = rd_val;
          out_data_nxt.cursor_x  = cursor_col_r;
          out_data_nxt.cursor_y  = cursor_row_r;
          sweep_item_nxt         = 1'b0;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      func_r        <= FUNC_FILL;
      rd_ok_r       <= 1'b0;
      font_width_r  <= FONT_WIDTH_RST;
      font_height_r <= FONT_HEIGHT_RST;
      cursor_col_r  <= 8'd0;
      cursor_row_r  <= 8'd0;
      fa_r          <= '0;
      fill_val_r    <= 1'b0;
      sweep_item_r  <= 1'b0;
      k_r           <= '0;
      i_r           <= '0;
      j_r           <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      func_r       <= func_nxt;
      rd_ok_r      <= rd_ok_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      fa_r         <= fa_nxt;
      fill_val_r   <= fill_val_nxt;
      sweep_item_r <= sweep_item_nxt;
      k_r          <= k_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FONT_WIDTH:  font_width_r  <= cfg_wdata[4:0];
          CFG_FONT_HEIGHT: font_height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r    <= color_nxt;
    red_r      <= red_nxt;
    ga_r       <= ga_nxt;
    word_r     <= word_nxt;
    shift_r    <= shift_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    pa_r       <= pa_nxt;
    pbit_r     <= pbit_nxt;
    pval_r     <= pval_nxt;
    out_data_r <= out_data_nxt;
  end

  ofbtr_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .re    (fb_re),
    .raddr (fb_raddr),
    .rdata (fb_q)
  );

  ofbtr_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (gl_we),
    .waddr (ga_r),
    .wdata (word_r),
    .re    (gl_re),
    .raddr (gl_raddr),
    .rdata (gl_q)
  );

endmodule
